FILE: sv/aalw_pkg.sv
// Shared types, constants and helpers for the ANSI-aware line wrapper.
`timescale 1ns / 1ps
`default_nettype none
package aalw_pkg;

	localparam int unsigned LINE_BYTES_DEF = 4096;
	localparam int unsigned OUTQ_DEPTH_DEF = 8;
	localparam int unsigned MAX_RESULTS    = 3;
	localparam int unsigned IDX_W          = 12;

	localparam logic [7:0] ESC_BYTE      = 8'h1B;
	localparam logic [7:0] OPEN_BRACKET  = 8'h5B;
	localparam logic [7:0] SPACE_BYTE    = 8'h20;
	localparam logic [7:0] DEFAULT_LIMIT = 8'd80;

	typedef struct packed {
		logic [IDX_W-1:0] chunk_start;
		logic [IDX_W-1:0] chunk_end;
		logic             line_done;
		logic             too_long;
		logic             last;
	} result_t;

	// Results of one accepted byte, packed toward index 0.
	typedef struct packed {
		logic    [MAX_RESULTS-1:0] vld;
		result_t [MAX_RESULTS-1:0] res;
	} push_t;

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

endpackage
`default_nettype wire

FILE: sv/aalw_core.sv
// Scanner: escape tracking, visible count and chunk cuts for one byte per cycle while in_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module aalw_core #(
	parameter int unsigned LINE_BYTES = aalw_pkg::LINE_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_wdata,
	input  wire logic            in_valid,
	input  wire logic            in_ready,
	input  wire logic [7:0]      text_byte,
	input  wire logic            line_end,
	output aalw_pkg::push_t      push
);

	localparam int unsigned PW = $clog2(LINE_BYTES);
	localparam int unsigned CW = PW + 1;
	localparam int unsigned VW = (CW > 8) ? CW : 8;
	localparam int unsigned XW = (CW > aalw_pkg::IDX_W) ? CW : aalw_pkg::IDX_W;

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_SEQ  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CW-1:0] cb;
		logic [PW-1:0] sp;
		logic          ss;
		logic [CW-1:0] vc;
	} scan_t;

	typedef struct packed {
		scan_t         st;
		logic          cut;
		logic [CW-1:0] cs;
		logic [CW-1:0] ce;
	} step_t;

	function automatic step_t take_step(input scan_t s, input logic [CW-1:0] i,
		input logic vis, input logic spc, input logic [PW-1:0] spos,
		input logic [7:0] lim);
		step_t         r;
		logic [CW-1:0] split;
		r     = '0;
		r.st  = s;
		split = '0;
		if (spc) begin
			r.st.ss = 1'b1;
			r.st.sp = spos;
		end
		if (vis && (r.st.vc < CW'(LINE_BYTES)))
			r.st.vc = r.st.vc + 1'b1;
		if (VW'(r.st.vc) > VW'(lim)) begin
			split   = r.st.ss ? CW'(r.st.sp) : (i - 1'b1);
			r.cut   = 1'b1;
			r.cs    = r.st.cb;
			r.ce    = split;
			r.st.cb = split + 1'b1;
			r.st.vc = (i >= r.st.cb) ? (i - r.st.cb) : '0;
			r.st.ss = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [aalw_pkg::IDX_W-1:0] to_idx(input logic [CW-1:0] v);
		logic [XW-1:0] x;
		x = XW'(v);
		return x[aalw_pkg::IDX_W-1:0];
	endfunction

	logic [7:0]    limit_q;
	logic [PW-1:0] pos_q;
	scan_t         scan_q;
	mode_t         mode_q;
	logic          ovf_q;

	logic          accept;
	mode_t         mode_d;
	logic          normal;
	logic          en_a, vis_a, en_b;
	logic [CW-1:0] i_here, i_esc, i_a;
	step_t         step_a, step_b;
	scan_t         scan_a, scan_b;
	logic          fin_v;
	logic [CW-1:0] fin_s;
	aalw_pkg::result_t [aalw_pkg::MAX_RESULTS-1:0] slot;
	logic [aalw_pkg::MAX_RESULTS-1:0] sv;
	logic [1:0]    k;

	assign accept = in_valid && in_ready;

	always_comb begin
		i_here = CW'(pos_q) + 1'b1;
		i_esc  = ovf_q ? CW'(LINE_BYTES) : ((pos_q != '0) ? CW'(pos_q) : CW'(1));
		mode_d = mode_q;
		normal = 1'b0;
		en_a   = 1'b0;
		vis_a  = 1'b0;
		i_a    = i_here;
		en_b   = 1'b0;
		unique case (mode_q)
			MODE_SEQ: begin
				if (aalw_pkg::is_letter(text_byte) || line_end) begin
					mode_d = MODE_TEXT;
					en_a   = 1'b1;
				end
			end
			MODE_ESC: begin
				if (text_byte == aalw_pkg::OPEN_BRACKET) begin
					mode_d = MODE_SEQ;
					if (line_end) begin
						mode_d = MODE_TEXT;
						en_a   = 1'b1;
					end
				end else begin
					// lone ESC: its column lands now
					mode_d = MODE_TEXT;
					en_a   = 1'b1;
					vis_a  = 1'b1;
					i_a    = i_esc;
					normal = 1'b1;
				end
			end
			default: begin
				mode_d = MODE_TEXT;
				normal = 1'b1;
			end
		endcase
		if (normal) begin
			if ((text_byte == aalw_pkg::ESC_BYTE) && !line_end)
				mode_d = MODE_ESC;
			else
				en_b = 1'b1;
		end

		step_a = take_step(scan_q, i_a, vis_a, 1'b0, '0, limit_q);
		if (!en_a)
			step_a = '{st: scan_q, cut: 1'b0, cs: '0, ce: '0};
		scan_a = step_a.st;
		step_b = take_step(scan_a, i_here, 1'b1, text_byte == aalw_pkg::SPACE_BYTE,
			pos_q, limit_q);
		if (!en_b)
			step_b = '{st: scan_a, cut: 1'b0, cs: '0, ce: '0};
		scan_b = step_b.st;

		// remainder at line end, or a marker if nothing else came out
		fin_v = 1'b0;
		fin_s = CW'(pos_q);
		if (line_end) begin
			if (scan_b.cb <= CW'(pos_q)) begin
				fin_v = 1'b1;
				fin_s = scan_b.cb;
			end else if (!step_a.cut && !step_b.cut) begin
				fin_v = 1'b1;
			end
		end

		sv = {fin_v, step_b.cut, step_a.cut};
		slot[0] = '{chunk_start: to_idx(step_a.cs), chunk_end: to_idx(step_a.ce),
			line_done: 1'b0, too_long: ovf_q, last: 1'b0};
		slot[1] = '{chunk_start: to_idx(step_b.cs), chunk_end: to_idx(step_b.ce),
			line_done: 1'b0, too_long: ovf_q, last: 1'b0};
		slot[2] = '{chunk_start: to_idx(fin_s), chunk_end: to_idx(CW'(pos_q)),
			line_done: 1'b0, too_long: ovf_q, last: 1'b0};
		slot[0].last = sv[0] && !sv[1] && !sv[2];
		slot[1].last = sv[1] && !sv[2];
		slot[2].last = sv[2];
		for (int j = 0; j < aalw_pkg::MAX_RESULTS; j++)
			slot[j].line_done = line_end && slot[j].last;

		push = '0;
		k    = '0;
		for (int j = 0; j < aalw_pkg::MAX_RESULTS; j++) begin
			if (sv[j] && accept) begin
				push.res[k] = slot[j];
				push.vld[k] = 1'b1;
				k = k + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= aalw_pkg::DEFAULT_LIMIT;
			pos_q   <= '0;
			scan_q  <= '0;
			mode_q  <= MODE_TEXT;
			ovf_q   <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (accept) begin
				if (line_end) begin
					pos_q  <= '0;
					scan_q <= '0;
					mode_q <= MODE_TEXT;
					ovf_q  <= 1'b0;
				end else begin
					scan_q <= scan_b;
					mode_q <= mode_d;
					if (pos_q < PW'(LINE_BYTES - 1))
						pos_q <= pos_q + 1'b1;
					else
						ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/aalw_outq.sv
// Result queue: takes up to three results a cycle, hands out one per beat.
`timescale 1ns / 1ps
`default_nettype none
module aalw_outq #(
	parameter int unsigned DEPTH = aalw_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire aalw_pkg::push_t    push,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output aalw_pkg::result_t       head
);

	localparam int unsigned AW = $clog2(DEPTH);

	aalw_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   cnt_q;
	logic [AW:0]   push_n;
	logic          pop;

	assign push_n    = (AW+1)'(push.vld[0]) + (AW+1)'(push.vld[1]) + (AW+1)'(push.vld[2]);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	// need space for a worst-case byte
	assign room      = (cnt_q <= (AW+1)'(DEPTH - aalw_pkg::MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int j = 0; j < aalw_pkg::MAX_RESULTS; j++)
			if (push.vld[j])
				mem_q[wr_ptr_q + AW'(j)] <= push.res[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[AW-1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + push_n - (AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: sv/ansi_aware_line_wrapper.sv
// ANSI-aware line wrapper top level.
// Takes one byte of a text line per cycle and cuts the line into chunks of at most
// column_limit visible columns, breaking at the last space where there is one;
// ESC [ ... letter sequences take no columns. Each byte is scanned in the cycle it
// is accepted and yields zero to three result beats, which go into a queue of
// OUTQ_DEPTH entries that drains one beat per cycle. in_ready is high while the
// queue has room for three more results, so with a ready output and at most one
// result per byte the block takes a byte every cycle; bytes that cause more than
// one result slow the input to the one-beat-per-cycle output rate.
`timescale 1ns / 1ps
`default_nettype none
module ansi_aware_line_wrapper #(
	parameter int unsigned LINE_BYTES = aalw_pkg::LINE_BYTES_DEF,
	parameter int unsigned OUTQ_DEPTH = aalw_pkg::OUTQ_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      chunk_start,
	output logic [11:0]      chunk_end,
	output logic             line_done,
	output logic             too_long,
	output logic             last
);

	aalw_pkg::push_t   push;
	aalw_pkg::result_t head;

	aalw_core #(.LINE_BYTES(LINE_BYTES)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.text_byte (text_byte),
		.line_end  (line_end),
		.push      (push)
	);

	aalw_outq #(.DEPTH(OUTQ_DEPTH)) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign chunk_start = head.chunk_start;
	assign chunk_end   = head.chunk_end;
	assign line_done   = head.line_done;
	assign too_long    = head.too_long;
	assign last        = head.last;

endmodule
`default_nettype wire

FILE: sv/aalw_checker.sv
// Port-level checks for the line wrapper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module aalw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        line_end,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] chunk_start,
	input wire logic [11:0] chunk_end,
	input wire logic        line_done,
	input wire logic        last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_start) && $stable(chunk_end)
			&& $stable(line_done) && $stable(last))
		else $error("result beat changed while stalled");

	// the final chunk of a line is always the last beat of its byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last)
		else $error("line_done without last");

	// a line-end byte always yields a result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && line_end |=> out_valid)
		else $error("no result after line end");

	// an empty queue always has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind ansi_aware_line_wrapper aalw_checker u_aalw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.line_end    (line_end),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.chunk_start (chunk_start),
	.chunk_end   (chunk_end),
	.line_done   (line_done),
	.last        (last)
);
`default_nettype wire

FILE: sim/ansi_aware_line_wrapper_checker.sv
// Checker for the line wrapper: tracks both channels, predicts chunks, compares beats.
`timescale 1ns / 1ps
module ansi_aware_line_wrapper_checker #(
	parameter int unsigned LINE_BYTES = aalw_pkg::LINE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        line_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [11:0] chunk_start,
	input  logic [11:0] chunk_end,
	input  logic        line_done,
	input  logic        too_long,
	input  logic        last,
	output int          fails,
	output int          pending,
	output int          checked
);

	// wide enough to hold LINE_BYTES itself
	typedef logic [$clog2(LINE_BYTES):0] pos_t;
	typedef enum logic [1:0] {SCAN_TEXT, SCAN_ESC, SCAN_SEQ} scan_t;

	logic [7:0] col_limit;
	pos_t       byte_pos;
	pos_t       chunk_beg;
	pos_t       space_pos;
	logic       space_hit;
	pos_t       vis_cnt;
	scan_t      scan_state;
	logic       overflow;

	aalw_pkg::result_t step_q[$];
	aalw_pkg::result_t chunk_q[$];

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	task automatic clear_line();
		byte_pos   = '0;
		chunk_beg  = '0;
		space_pos  = '0;
		space_hit  = 1'b0;
		vis_cnt    = '0;
		scan_state = SCAN_TEXT;
		overflow   = 1'b0;
	endtask

	task automatic emit_chunk(input pos_t s, input pos_t e, input logic too);
		aalw_pkg::result_t r;
		r.chunk_start = 12'(s);
		r.chunk_end   = 12'(e);
		r.line_done   = 1'b0;
		r.too_long    = too;
		r.last        = 1'b0;
		step_q.push_back(r);
	endtask

	// Count one column (or none) ending just before index i; cut when over the limit.
	task automatic count_column(input pos_t i, input logic visible, input logic space,
			input pos_t spos, input logic too);
		pos_t split;
		if (space) begin
			space_hit = 1'b1;
			space_pos = spos;
		end
		if (visible && vis_cnt < LINE_BYTES)
			vis_cnt = vis_cnt + 1'b1;
		if (vis_cnt > col_limit) begin
			split = space_hit ? space_pos : pos_t'(i - 1'b1);
			emit_chunk(chunk_beg, split, too);
			chunk_beg = split + 1'b1;
			vis_cnt   = (i >= chunk_beg) ? pos_t'(i - chunk_beg) : '0;
			space_hit = 1'b0;
		end
	endtask

	task automatic wrap_byte(input logic [7:0] b, input logic e);
		logic    too;
		logic    normal;
		pos_t    p;
		pos_t    i_here;
		pos_t    i_esc;
		aalw_pkg::result_t r;
		too    = overflow;
		p      = byte_pos;
		i_here = p + 1'b1;
		i_esc  = too ? pos_t'(LINE_BYTES) : ((p != 0) ? p : pos_t'(1));
		normal = 1'b0;
		step_q.delete();
		case (scan_state)
			SCAN_SEQ: begin
				// a line end closes an open sequence
				if (is_alpha(b) || e) begin
					scan_state = SCAN_TEXT;
					count_column(i_here, 1'b0, 1'b0, '0, too);
				end
			end
			SCAN_ESC: begin
				if (b == aalw_pkg::OPEN_BRACKET) begin
					scan_state = SCAN_SEQ;
					if (e) begin
						scan_state = SCAN_TEXT;
						count_column(i_here, 1'b0, 1'b0, '0, too);
					end
				end else begin
					// lone ESC: its column is counted now
					scan_state = SCAN_TEXT;
					count_column(i_esc, 1'b1, 1'b0, '0, too);
					normal = 1'b1;
				end
			end
			default: begin
				scan_state = SCAN_TEXT;
				normal = 1'b1;
			end
		endcase
		if (normal) begin
			if (b == aalw_pkg::ESC_BYTE && !e)
				scan_state = SCAN_ESC;
			else
				count_column(i_here, 1'b1, b == aalw_pkg::SPACE_BYTE, p, too);
		end
		if (e) begin
			if (chunk_beg <= p)
				emit_chunk(chunk_beg, p, too);
			else if (step_q.size() == 0)
				emit_chunk(p, p, too);
			r = step_q.pop_back();
			r.line_done = 1'b1;
			step_q.push_back(r);
			clear_line();
		end else if (p < LINE_BYTES - 1) begin
			byte_pos = p + 1'b1;
		end else begin
			overflow = 1'b1;
		end
		if (step_q.size() > 0) begin
			r = step_q.pop_back();
			r.last = 1'b1;
			step_q.push_back(r);
		end
		foreach (step_q[k])
			chunk_q.push_back(step_q[k]);
	endtask

	task automatic check_beat();
		aalw_pkg::result_t want;
		if (chunk_q.size() == 0) begin
			$error("unexpected chunk beat: start %0d end %0d", chunk_start, chunk_end);
			fails++;
		end else begin
			want = chunk_q.pop_front();
			checked++;
			if (chunk_start !== want.chunk_start) begin
				$error("chunk_start: expected %0d, got %0d", want.chunk_start, chunk_start);
				fails++;
			end
			if (chunk_end !== want.chunk_end) begin
				$error("chunk_end: expected %0d, got %0d", want.chunk_end, chunk_end);
				fails++;
			end
			if (line_done !== want.line_done) begin
				$error("line_done: expected %0d, got %0d", want.line_done, line_done);
				fails++;
			end
			if (too_long !== want.too_long) begin
				$error("too_long: expected %0d, got %0d", want.too_long, too_long);
				fails++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			col_limit = aalw_pkg::DEFAULT_LIMIT;
			chunk_q.delete();
			fails   = 0;
			pending = 0;
			checked = 0;
		end else begin
			// output beats come from earlier bytes, so retire before predicting
			if (out_valid && out_ready)
				check_beat();
			if (cfg_we)
				col_limit = cfg_wdata;
			if (in_valid && in_ready)
				wrap_byte(text_byte, line_end);
			pending = chunk_q.size();
		end
	end

endmodule

FILE: sim/ansi_aware_line_wrapper_test.sv
// Testbench top for the line wrapper: clock, reset, byte stimulus, receiver and verdict.
`timescale 1ns / 1ps
module ansi_aware_line_wrapper_test;

	localparam int unsigned LINE_BYTES  = aalw_pkg::LINE_BYTES_DEF;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          HOLD_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  text_byte;
	logic        line_end;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] chunk_start;
	logic [11:0] chunk_end;
	logic        line_done;
	logic        too_long;
	logic        last;

	int          fails;
	int          pending;
	int          checked;

	logic [7:0]  line_q[$];
	int          n_bytes;
	int          n_lines;
	bit          idle_on;
	bit          hold_req;

	ansi_aware_line_wrapper #(.LINE_BYTES(LINE_BYTES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chunk_start(chunk_start),
		.chunk_end(chunk_end),
		.line_done(line_done),
		.too_long(too_long),
		.last(last)
	);

	ansi_aware_line_wrapper_checker #(.LINE_BYTES(LINE_BYTES)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chunk_start(chunk_start),
		.chunk_end(chunk_end),
		.line_done(line_done),
		.too_long(too_long),
		.last(last),
		.fails(fails),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one byte and hold it until the beat is taken
	task automatic send_beat(input logic [7:0] b, input logic e);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		text_byte <= b;
		line_end  <= e;
		do
			@(posedge clk);
		while (!in_ready);
		n_bytes++;
	endtask

	task automatic send_line();
		foreach (line_q[k])
			send_beat(line_q[k], k == line_q.size() - 1);
		n_lines++;
	endtask

	// random line of exactly n bytes: text, spaces, sequences, lone and broken escapes
	task automatic fill_line(input int n);
		int kind;
		int nd;
		int c;
		line_q.delete();
		while (line_q.size() < n) begin
			kind = $urandom_range(0, 99);
			c = $urandom_range(0, 51);
			if (kind < 35) begin
				line_q.push_back(c < 26 ? 8'(8'h41 + c) : 8'(8'h61 + c - 26));
			end else if (kind < 52) begin
				line_q.push_back(aalw_pkg::SPACE_BYTE);
			end else if (kind < 68) begin
				line_q.push_back(aalw_pkg::ESC_BYTE);
				line_q.push_back(aalw_pkg::OPEN_BRACKET);
				nd = $urandom_range(0, 3);
				repeat (nd)
					line_q.push_back($urandom_range(0, 5) == 0 ? 8'h3B :
						8'(8'h30 + $urandom_range(0, 9)));
				line_q.push_back(c < 26 ? 8'(8'h41 + c) : 8'(8'h61 + c - 26));
			end else if (kind < 74) begin
				line_q.push_back(aalw_pkg::ESC_BYTE);
			end else if (kind < 80) begin
				line_q.push_back(aalw_pkg::ESC_BYTE);
				line_q.push_back(aalw_pkg::OPEN_BRACKET);
				line_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				line_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		while (line_q.size() > n)
			void'(line_q.pop_back());
	endtask

	// stop offering, then let every chunk arrive
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		wait_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(0, 99) < 16);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [7:0] limits[7];
		int         ph_bytes;
		int         target;
		bit         held;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 8'h00;
		in_valid  = 1'b0;
		text_byte = 8'h00;
		line_end  = 1'b0;
		n_bytes   = 0;
		n_lines   = 0;
		idle_on   = 1'b1;
		hold_req  = 1'b0;
		held      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed lines under the reset limit
		line_q = '{8'h00};
		send_line();
		// line ends on a lone ESC
		line_q = '{8'h41, aalw_pkg::SPACE_BYTE, aalw_pkg::ESC_BYTE};
		send_line();
		// line ends inside a sequence
		line_q = '{aalw_pkg::ESC_BYTE, aalw_pkg::OPEN_BRACKET, 8'h33, 8'h31};
		send_line();
		line_q = '{aalw_pkg::ESC_BYTE, 8'h78, aalw_pkg::ESC_BYTE, aalw_pkg::OPEN_BRACKET,
			8'h6D, 8'hFF};
		send_line();
		// zero limit: every visible byte cuts and becomes a chunk of its own
		write_limit(8'd0);
		line_q = '{8'h61, 8'h62};
		send_line();
		line_q = '{aalw_pkg::ESC_BYTE, 8'h7A, aalw_pkg::SPACE_BYTE};
		send_line();
		write_limit(8'd255);
		line_q = '{8'h7F, aalw_pkg::SPACE_BYTE, 8'h80, 8'h5A};
		send_line();

		// random phases; phase 3 holds the receiver off, phase 5 runs without gaps
		limits = '{8'd1, 8'd255, 8'd3, 8'd1, 8'd0, 8'd0, 8'd80};
		limits[2] = 8'($urandom_range(2, 20));
		limits[5] = 8'($urandom_range(1, 255));
		for (int ph = 0; ph < 7; ph++) begin
			write_limit(limits[ph]);
			ph_bytes = n_bytes;
			target = (ph == 5) ? 30 : 14;
			while (n_bytes - ph_bytes < target) begin
				// a full line under a tight limit keeps offering while the receiver holds
				if (ph == 3 && !held) begin
					hold_req = 1'b1;
					held = 1'b1;
					fill_line(16);
				end else begin
					fill_line($urandom_range(1, 16));
				end
				send_line();
				idle_on = (ph != 5);
			end
		end

		wait_drain();
		repeat (10) @(negedge clk);
		$display("covered %0d bytes in %0d lines, %0d chunks compared", n_bytes, n_lines,
			checked);
		$display("limits from 0 to 255, escapes lone, broken and open at line end");
		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
